/* rtl/stl_pkg.sv */
package stl_pkg;

   // Core sizes
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
   localparam int PHASE_BITS       = 24;
   localparam int REG_BITS         = 24;
   localparam int SAMPLE_BITS      = 24;
   localparam int DEPTH_BITS       = 17;
   localparam int LFO_BITS         = 17;
   localparam int MUL_A_BITS       = 25;
   localparam int MUL_B_BITS       = 18;
   localparam int MUL_P_BITS       = MUL_A_BITS + MUL_B_BITS;
   localparam int CSR_INDEX_BITS   = 3;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEPTH         = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVE_SHAPE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPREAD_OFFSET = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEREO_ENABLE = 3'd4;

   // Register reset values
   localparam logic [REG_BITS-1:0]   PHASE_STEP_RESET = 24'd2796;
   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET      = 17'd32768;
   localparam logic [DEPTH_BITS-1:0] DEPTH_FULL       = 17'd65536;

   // Wave shape codes
   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_SAWTOOTH = 2'd3
   } wave_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEP_L,
      ST_SAMP_L,
      ST_DEP_R,
      ST_SAMP_R,
      ST_PUT
   } state_type;

   // Quarter-wave sine table, Q15 magnitude, SINE_TABLE_DEPTH+1 entries
   typedef logic [15:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

   // Taylor series in Q30, evaluated at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  v;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (Q30_HALF_PI * 64'(i)) / SINE_TABLE_DEPTH;
         term = x;
         sum  = x;
         for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (k)
               1: term = term / 64'd6;
               2: term = term / 64'd20;
               3: term = term / 64'd42;
               4: term = term / 64'd72;
               5: term = term / 64'd110;
               default: term = term / 64'd156;
            endcase
            if (k % 2 == 1) begin
               sum = (sum > term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum + 64'd16384) >> 15;
         if (v > 64'd32768) begin
            v = 64'd32768;
         end
         rom[i] = v[15:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Register values are in 2^24 units; bring them to phase units
   function automatic logic [PHASE_BITS-1:0] scale_reg(input logic [REG_BITS-1:0] x);
      logic [PHASE_BITS+REG_BITS-1:0] wide;
      wide = {{PHASE_BITS{1'b0}}, x};
      wide = wide << ((PHASE_BITS > REG_BITS) ? (PHASE_BITS - REG_BITS) : 0);
      wide = wide >> ((PHASE_BITS < REG_BITS) ? (REG_BITS - PHASE_BITS) : 0);
      return wide[PHASE_BITS-1:0];
   endfunction

endpackage

/* rtl/stl_lfo.sv */
module stl_lfo (
   input  logic [stl_pkg::PHASE_BITS-1:0]   phase,
   input  stl_pkg::wave_type                shape,
   output logic signed [stl_pkg::LFO_BITS-1:0] lfo
);
   import stl_pkg::*;

   logic [15:0]                 u;
   logic [SINE_ADDR_BITS:0]     r_idx;
   logic [SINE_ADDR_BITS:0]     idx;
   logic [15:0]                 sine_mag;
   logic signed [LFO_BITS-1:0]  sine_v;
   logic signed [LFO_BITS-1:0]  centred;
   logic signed [LFO_BITS-1:0]  tri_mag;
   logic signed [LFO_BITS:0]    tri_wide;

   // Top 16 phase bits; quarter-wave lookup mirrored and negated by quadrant
   always_comb begin
      u        = phase[PHASE_BITS-1 -: 16];
      r_idx    = (SINE_ADDR_BITS+1)'(u[13:0] >> (14 - SINE_ADDR_BITS));
      if (u[14]) begin
         idx = (SINE_ADDR_BITS+1)'(SINE_TABLE_DEPTH) - r_idx;
      end else begin
         idx = r_idx;
      end
      sine_mag = SINE_ROM[idx];
      if (u[15]) begin
         sine_v = -$signed({1'b0, sine_mag});
      end else begin
         sine_v = $signed({1'b0, sine_mag});
      end
   end

   // Sawtooth and triangle share the centred phase
   always_comb begin
      centred  = $signed({1'b0, u}) - 17'sd32768;
      tri_mag  = (centred < 0) ? -centred : centred;
      tri_wide = ($signed({tri_mag, 1'b0})) - 18'sd32768;
   end

   always_comb begin
      case (shape)
         WAVE_SINE:     lfo = sine_v;
         WAVE_SQUARE:   lfo = u[15] ? -17'sd32768 : 17'sd32768;
         WAVE_TRIANGLE: lfo = tri_wide[LFO_BITS-1:0];
         WAVE_SAWTOOTH: lfo = centred;
         default:       lfo = centred;
      endcase
   end

endmodule

/* rtl/stl_mul.sv */
module stl_mul (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [stl_pkg::MUL_A_BITS-1:0]  a,
   input  logic signed [stl_pkg::MUL_B_BITS-1:0]  b,
   output logic signed [stl_pkg::MUL_P_BITS-1:0]  p
);
   import stl_pkg::*;

   logic signed [MUL_P_BITS-1:0] prod_ff;

   // Shared registered multiplier; holds its product while not enabled
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
      end
   end

   assign p = prod_ff;

endmodule

/* rtl/stereo_tremolo_lfo_core.sv */
// Stereo tremolo: each accepted frame is scaled per channel by a gain of
// 1 - depth*(1 - lfo)/2, where the LFO (sine, square, triangle or sawtooth)
// is read at the running phase for the left channel and at phase plus the
// spread offset for the right (unscaled if stereo_enable is clear); the
// phase then advances by phase_step. One registered multiplier does all the
// arithmetic in four passes (depth times LFO term, then sample times gain,
// for each channel) in ST_DEP_L, ST_SAMP_L, ST_DEP_R and ST_SAMP_R; ST_PUT
// then waits while a held result is stalled. req_stall is high while a frame
// is in work. Configuration writes are always taken (csr_ready is tied high)
// and should only be made while no frame is in work.
module stereo_tremolo_lfo_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [stl_pkg::SAMPLE_BITS-1:0]    req_left_sample,
   input  logic signed [stl_pkg::SAMPLE_BITS-1:0]    req_right_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [stl_pkg::SAMPLE_BITS-1:0]    rsp_left_out,
   output logic signed [stl_pkg::SAMPLE_BITS-1:0]    rsp_right_out,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [stl_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [stl_pkg::REG_BITS-1:0]              csr_wdata
);
   import stl_pkg::*;

   // Configuration registers
   logic [REG_BITS-1:0]   phase_step_ff;
   logic [DEPTH_BITS-1:0] depth_ff;
   wave_type              wave_shape_ff;
   logic [REG_BITS-1:0]   spread_offset_ff;
   logic                  stereo_enable_ff;

   // Datapath state
   state_type                     state_ff, state_in;
   logic [PHASE_BITS-1:0]         lfo_phase_ff;
   logic [DEPTH_BITS-1:0]         h_left_ff, h_right_ff;
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;
   logic signed [SAMPLE_BITS-1:0] left_res_ff;
   logic signed [SAMPLE_BITS-1:0] out_left_ff, out_right_ff;
   logic                          rsp_valid_ff;

   logic                          req_xfer;
   logic                          rsp_xfer;
   logic                          csr_xfer;
   logic [PHASE_BITS-1:0]         step_scaled;
   logic [PHASE_BITS-1:0]         phase_right;
   logic signed [LFO_BITS-1:0]    lfo_left, lfo_right;
   logic [DEPTH_BITS-1:0]         dep_sat;
   logic [DEPTH_BITS:0]           dh;
   logic [DEPTH_BITS-1:0]         gain;
   logic signed [MUL_P_BITS-1:0]  prod;
   logic signed [MUL_P_BITS-1:0]  rounded;
   logic signed [SAMPLE_BITS-1:0] sample_res;

   // Sequencer outputs
   logic                          mul_en;
   logic signed [MUL_A_BITS-1:0]  mul_a;
   logic signed [MUL_B_BITS-1:0]  mul_b;
   logic                          load_left;
   logic                          load_out;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= PHASE_STEP_RESET;
         depth_ff         <= DEPTH_RESET;
         wave_shape_ff    <= WAVE_SINE;
         spread_offset_ff <= '0;
         stereo_enable_ff <= 1'b1;
      end else if (csr_xfer) begin
         case (csr_index)
            CSR_PHASE_STEP:    phase_step_ff    <= csr_wdata;
            CSR_DEPTH:         depth_ff         <= csr_wdata[DEPTH_BITS-1:0];
            CSR_WAVE_SHAPE:    wave_shape_ff    <= wave_type'(csr_wdata[1:0]);
            CSR_SPREAD_OFFSET: spread_offset_ff <= csr_wdata;
            CSR_STEREO_ENABLE: stereo_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // LFO reads: left at the current phase, right at phase plus the spread offset
   assign step_scaled = scale_reg(phase_step_ff);
   assign phase_right = lfo_phase_ff + scale_reg(spread_offset_ff);

   stl_lfo u_lfo_left (
      .phase (lfo_phase_ff),
      .shape (wave_shape_ff),
      .lfo   (lfo_left)
   );

   stl_lfo u_lfo_right (
      .phase (phase_right),
      .shape (wave_shape_ff),
      .lfo   (lfo_right)
   );

   // Frame capture and phase advance on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         lfo_phase_ff <= '0;
      end else if (req_xfer) begin
         lfo_phase_ff <= lfo_phase_ff + step_scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         left_ff    <= req_left_sample;
         right_ff   <= req_right_sample;
         h_left_ff  <= DEPTH_BITS'(18'sd32768 - 18'(lfo_left));
         h_right_ff <= DEPTH_BITS'(18'sd32768 - 18'(lfo_right));
      end
   end

   // Post-multiply arithmetic: gain from depth product, rounded sample result
   assign dep_sat    = (depth_ff > DEPTH_FULL) ? DEPTH_FULL : depth_ff;
   assign dh         = (DEPTH_BITS+1)'((prod[33:0] + 34'd32768) >> 16);
   assign gain       = DEPTH_BITS'(18'd65536 - dh);
   assign rounded    = prod + MUL_P_BITS'(32768);
   assign sample_res = rounded[SAMPLE_BITS+15:16];

   stl_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_DEP_L;
         ST_DEP_L:  state_in = ST_SAMP_L;
         ST_SAMP_L: state_in = ST_DEP_R;
         ST_DEP_R:  state_in = ST_SAMP_R;
         ST_SAMP_R: state_in = ST_PUT;
         ST_PUT:    if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer: outputs and multiplier operand selection
   always_comb begin
      req_stall = 1'b1;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      load_left = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_DEP_L: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_BITS'({1'b0, dep_sat});
            mul_b  = MUL_B_BITS'({1'b0, h_left_ff});
         end
         ST_SAMP_L: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_BITS'(left_ff);
            mul_b  = MUL_B_BITS'({1'b0, gain});
         end
         ST_DEP_R: begin
            load_left = 1'b1;
            mul_en    = 1'b1;
            mul_a     = MUL_A_BITS'({1'b0, dep_sat});
            mul_b     = MUL_B_BITS'({1'b0, h_right_ff});
         end
         ST_SAMP_R: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_BITS'(right_ff);
            mul_b  = MUL_B_BITS'({1'b0, gain});
         end
         ST_PUT: begin
            load_out = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Left result waits while the multiplier works on the right channel
   always_ff @(posedge clock) begin
      if (load_left) begin
         left_res_ff <= sample_res;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_left_ff  <= left_res_ff;
         out_right_ff <= stereo_enable_ff ? sample_res : right_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = out_left_ff;
   assign rsp_right_out = out_right_ff;

   // Checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_DEP_L)
      else $error("frame transfer did not start the sequence");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> lfo_phase_ff == $past(lfo_phase_ff + step_scaled))
      else $error("phase did not advance by one step");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_PUT)
      else $error("result shown outside the put step");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAMP_L || state_ff == ST_SAMP_R) |-> gain <= DEPTH_FULL)
      else $error("gain out of range");

endmodule

/* test/tb_stereo_tremolo_lfo_core.sv */
module tb_stereo_tremolo_lfo_core;
   import stl_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_IDLE    = 11;
   localparam int RANDOM_FRAMES = 1000;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_frame_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   sample_type                req_left_sample;
   sample_type                req_right_sample;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   sample_type                rsp_left_out;
   sample_type                rsp_right_out;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [REG_BITS-1:0]       csr_wdata;

   // Predictor state: phase accumulator and its own copy of the registers
   logic [PHASE_BITS-1:0]     phase_acc;
   logic [REG_BITS-1:0]       step_reg;
   logic [DEPTH_BITS-1:0]     depth_reg;
   wave_type                  shape_reg;
   logic [REG_BITS-1:0]       spread_reg;
   logic                      stereo_reg;
   int                        sine_q15 [0:SINE_TABLE_DEPTH];

   stereo_frame_type          pending_frames [$];
   int                        fail_count   = 0;
   int                        cycle_count  = 0;
   int                        sent_frames  = 0;
   int                        stall_budget = 0;
   bit                        no_idle      = 1'b0;

   stereo_tremolo_lfo_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Quarter-wave sine magnitudes, Q30 Taylor series rounded to Q15
   function automatic void fill_sine_table();
      longint unsigned ang, term, acc, rnd;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         ang  = (Q30_HALF_PI * i) / SINE_TABLE_DEPTH;
         term = ang;
         acc  = ang;
         for (int k = 1; k <= 6; k++) begin
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               acc = (acc > term) ? acc - term : 0;
            end else begin
               acc = acc + term;
            end
         end
         rnd = (acc + 16384) >> 15;
         sine_q15[i] = (rnd > 32768) ? 32768 : int'(rnd);
      end
   endfunction

   // LFO level in Q15, -32768..+32768, from the top 16 phase bits
   function automatic int lfo_level(input logic [PHASE_BITS-1:0] ph);
      logic [15:0] u;
      int          idx;
      int          mag;
      u = ph[PHASE_BITS-1 -: 16];
      case (shape_reg)
         WAVE_SINE: begin
            idx = (int'(u[13:0]) * SINE_TABLE_DEPTH) >> 14;
            if (u[14]) begin
               idx = SINE_TABLE_DEPTH - idx;
            end
            return u[15] ? -sine_q15[idx] : sine_q15[idx];
         end
         WAVE_SQUARE: return u[15] ? -32768 : 32768;
         WAVE_TRIANGLE: begin
            mag = int'(u) - 32768;
            if (mag < 0) begin
               mag = -mag;
            end
            return 2 * mag - 32768;
         end
         default: return int'(u) - 32768;
      endcase
   endfunction

   // gain = 1 - depth*(1 - lfo)/2 in Q16, then sample*gain rounded half up
   function automatic sample_type scale_sample(input sample_type s, input int lfo);
      longint dep, gain, prod;
      dep  = longint'((depth_reg > DEPTH_FULL) ? DEPTH_FULL : depth_reg);
      gain = 65536 - ((dep * (32768 - lfo) + 32768) >>> 16);
      prod = (longint'(s) * gain + 32768) >>> 16;
      return prod[SAMPLE_BITS-1:0];
   endfunction

   // Expected output of one accepted frame; advances the phase
   task automatic advance_tremolo(input sample_type l, input sample_type r);
      stereo_frame_type f;
      f.left = scale_sample(l, lfo_level(phase_acc));
      if (stereo_reg) begin
         f.right = scale_sample(r, lfo_level(phase_acc + scale_reg(spread_reg)));
      end else begin
         f.right = r;
      end
      pending_frames = {pending_frames, f};
      phase_acc = phase_acc + scale_reg(step_reg);
   endtask

   // Result checker; also draws the stall ahead of the next result
   always @(posedge clock) begin : check_results
      stereo_frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected result: left_out %0d right_out %0d",
                   rsp_left_out, rsp_right_out);
            fail_count++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_left_out !== want.left) begin
               $error("left_out: expected %0d, got %0d", want.left, rsp_left_out);
               fail_count++;
            end
            if (rsp_right_out !== want.right) begin
               $error("right_out: expected %0d, got %0d", want.right, rsp_right_out);
               fail_count++;
            end
         end
         stall_budget = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
   end

   // Receiver stall; counts down faster while a result is on offer
   always @(negedge clock) begin
      if (reset || stall_budget == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         if (rsp_valid || $urandom_range(0, 1)) begin
            stall_budget--;
         end
      end
   end

   // One frame transfer; valid is left high so back-to-back frames stay contiguous
   task automatic send_frame(input sample_type l, input sample_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_left_sample  <= l;
      req_right_sample <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_tremolo(l, r);
      sent_frames++;
   endtask

   // Drop valid and wait for every pending result
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [REG_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_PHASE_STEP:    step_reg   = data;
         CSR_DEPTH:         depth_reg  = data[DEPTH_BITS-1:0];
         CSR_WAVE_SHAPE:    shape_reg  = wave_type'(data[1:0]);
         CSR_SPREAD_OFFSET: spread_reg = data;
         CSR_STEREO_ENABLE: stereo_reg = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [REG_BITS-1:0] step,
                                 input logic [REG_BITS-1:0] dep,
                                 input logic [REG_BITS-1:0] shape,
                                 input logic [REG_BITS-1:0] spread,
                                 input logic [REG_BITS-1:0] stereo);
      wait_for_results();
      csr_write(CSR_PHASE_STEP, step);
      csr_write(CSR_DEPTH, dep);
      csr_write(CSR_WAVE_SHAPE, shape);
      csr_write(CSR_SPREAD_OFFSET, spread);
      csr_write(CSR_STEREO_ENABLE, stereo);
   endtask

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0:       return 24'sh7FFFFF;
         1:       return 24'sh800000;
         2:       return '0;
         3:       return '1;
         default: return sample_type'($urandom());
      endcase
   endfunction

   // Mostly modest rates, with the extremes of every register mixed in
   task automatic random_settings();
      logic [REG_BITS-1:0] step, dep, spread;
      case ($urandom_range(0, 3))
         0:       step = '0;
         1:       step = '1;
         2:       step = REG_BITS'($urandom_range(0, 65535));
         default: step = REG_BITS'($urandom());
      endcase
      case ($urandom_range(0, 3))
         0:       dep = '0;
         1:       dep = REG_BITS'(DEPTH_FULL);
         2:       dep = REG_BITS'($urandom_range(0, DEPTH_FULL));
         default: dep = REG_BITS'($urandom());
      endcase
      case ($urandom_range(0, 3))
         0:       spread = '0;
         1:       spread = 24'h800000;
         2:       spread = REG_BITS'($urandom_range(0, 24'h800000));
         default: spread = REG_BITS'($urandom());
      endcase
      apply_settings(step, dep, REG_BITS'($urandom()), spread, REG_BITS'($urandom()));
   endtask

   // Register values straight out of reset
   task automatic test_reset_values();
      send_frame(24'sh7FFFFF, 24'sh800000);
      send_frame(24'sh800000, 24'sh7FFFFF);
      send_frame('0, '1);
      send_frame(24'sd1, '0);
      send_frame(rand_sample(), rand_sample());
   endtask

   // Each shape at full depth, a quarter turn per frame, right half a turn ahead
   task automatic test_wave_shapes();
      wave_type shape;
      shape = WAVE_SINE;
      repeat (4) begin
         apply_settings(24'h400000, REG_BITS'(DEPTH_FULL), REG_BITS'(shape),
                        24'h800000, 24'd1);
         repeat (2) begin
            send_frame(24'sh7FFFFF, 24'sh800000);
            send_frame(24'sh800000, 24'sh7FFFFF);
         end
         shape = shape.next();
      end
   endtask

   // Depth above full, spread above half, largest step, mono, unused indexes
   task automatic test_register_edges();
      apply_settings('1, 24'h01FFFF, REG_BITS'(WAVE_TRIANGLE), '1, 24'd0);
      send_frame(24'sh7FFFFF, 24'sh7FFFFF);
      send_frame(24'sh800000, 24'sh800000);
      wait_for_results();
      for (int idx = CSR_STEREO_ENABLE + 1; idx < 2 ** CSR_INDEX_BITS; idx++) begin
         csr_write(CSR_INDEX_BITS'(idx), REG_BITS'($urandom()));
      end
      apply_settings(24'h123457, '0, REG_BITS'(WAVE_SAWTOOTH), 24'h654321, 24'd1);
      send_frame(24'sh7FFFFF, 24'sh800000);
      send_frame(rand_sample(), rand_sample());
   endtask

   // No gaps on either side
   task automatic test_back_to_back();
      random_settings();
      no_idle = 1'b1;
      repeat (100) send_frame(rand_sample(), rand_sample());
      wait_for_results();
      no_idle = 1'b0;
   endtask

   // Sender holds off until every result is back
   task automatic test_paced();
      random_settings();
      repeat (30) begin
         send_frame(rand_sample(), rand_sample());
         wait_for_results();
      end
   endtask

   task automatic test_random_phases();
      int start;
      int burst;
      start = sent_frames;
      while (sent_frames - start < RANDOM_FRAMES) begin
         random_settings();
         burst = $urandom_range(20, 120);
         if (burst > RANDOM_FRAMES - (sent_frames - start)) begin
            burst = RANDOM_FRAMES - (sent_frames - start);
         end
         repeat (burst) send_frame(rand_sample(), rand_sample());
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_left_sample  = '0;
      req_right_sample = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      fill_sine_table();
      phase_acc  = '0;
      step_reg   = PHASE_STEP_RESET;
      depth_reg  = DEPTH_RESET;
      shape_reg  = WAVE_SINE;
      spread_reg = '0;
      stereo_reg = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_wave_shapes();
      test_register_edges();
      test_back_to_back();
      test_paced();
      test_random_phases();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (pending_frames.size() != 0) begin
         $error("%0d results never arrived", pending_frames.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
